FILE: rtl/apv_pkg.sv
// Shared types, codes and fixed-point helpers of the annuity payment/value unit.
`default_nettype none
package apv_pkg;

  localparam int PERIOD_BITS = 12;
  localparam int AMOUNT_W    = 48;
  localparam int QUOT_BITS   = 48;
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

  typedef enum logic [1:0] {
    FN_PMT = 2'd0,
    FN_PV  = 2'd1,
    FN_FV  = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    func_t                      func;
    logic [31:0]                rate;
    logic [11:0]                periods;
    logic signed [AMOUNT_W-1:0] payment_in;
    logic signed [AMOUNT_W-1:0] present_in;
    logic signed [AMOUNT_W-1:0] future_in;
    logic                       at_start;
  } in_t;

  typedef struct packed {
    logic signed [AMOUNT_W-1:0] result_value;
    status_t                    status;
  } out_t;

  // growth pipeline word: s = geometric sum, g = growth, p = product / factor
  typedef struct packed {
    in_t              item;
    logic [63:0]      s;
    logic [63:0]      g;
    logic [63:0]      p;
    logic [63:0]      h;
    logic [3:0][63:0] pa;
    logic [3:0][63:0] pb;
    logic             big;
  } work_t;

  // quotient pipeline word
  typedef struct packed {
    func_t                      func;
    logic signed [AMOUNT_W-1:0] pmt;
    logic signed [AMOUNT_W-1:0] pv;
    logic signed [AMOUNT_W-1:0] fv;
    logic [63:0]                g;
    logic [63:0]                a;
    logic                       big;
    logic [3:0][63:0]           pa;
    logic [3:0][63:0]           pb;
    logic signed [113:0]        t1;
    logic signed [113:0]        t2;
    logic signed [114:0]        num;
    logic [115:0]               m;
    logic [63:0]                d;
    logic                       neg;
    logic [AMOUNT_W-1:0]        v2;
    logic                       sat2;
    logic                       dz;
    logic                       ovf;
    logic [63:0]                rem;
    logic [QUOT_BITS-1:0]       low;
    logic [QUOT_BITS-1:0]       q;
  } quot_t;

  // 32x32 partial products of two unsigned 64-bit operands
  function automatic logic [3:0][63:0] pprod(input logic [63:0] a, input logic [63:0] b);
    logic [3:0][63:0] pp;
    pp[0] = {32'b0, a[31:0]} * {32'b0, b[31:0]};
    pp[1] = {32'b0, a[31:0]} * {32'b0, b[63:32]};
    pp[2] = {32'b0, a[63:32]} * {32'b0, b[31:0]};
    pp[3] = {32'b0, a[63:32]} * {32'b0, b[63:32]};
    return pp;
  endfunction

  // Q32.32 product from partials, rounded to nearest; bit 64 flags a clamp
  function automatic logic [64:0] qjoin(input logic [3:0][63:0] pp);
    logic [127:0] p;
    p = {pp[3], pp[0]} + {32'b0, pp[1], 32'b0} + {32'b0, pp[2], 32'b0}
        + 128'h8000_0000;
    if (p[127:96] != 32'b0) return {1'b1, {64{1'b1}}};
    return {1'b0, p[95:32]};
  endfunction

  function automatic logic [64:0] qadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] r;
    r = {1'b0, a} + {1'b0, b};
    if (r[64]) return {1'b1, {64{1'b1}}};
    return r;
  endfunction

  // partials of a signed 48-bit amount times an unsigned 64-bit value
  function automatic logic [3:0][63:0] spprod(input logic [47:0] x, input logic [63:0] u);
    logic [3:0][63:0]   pp;
    logic signed [48:0] hl;
    logic signed [48:0] hh;
    pp[0] = {32'b0, x[31:0]} * {32'b0, u[31:0]};
    pp[1] = {32'b0, x[31:0]} * {32'b0, u[63:32]};
    hl = $signed({{33{x[47]}}, x[47:32]}) * $signed({17'b0, u[31:0]});
    hh = $signed({{33{x[47]}}, x[47:32]}) * $signed({17'b0, u[63:32]});
    pp[2] = {{15{hl[48]}}, hl};
    pp[3] = {{15{hh[48]}}, hh};
    return pp;
  endfunction

  function automatic logic signed [113:0] sjoin(input logic [3:0][63:0] pp);
    logic [113:0] t;
    t = {50'b0, pp[0]} + {18'b0, pp[1], 32'b0} + {{18{pp[2][63]}}, pp[2], 32'b0}
        + {pp[3][49:0], 64'b0};
    return $signed(t);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/apv_growth.sv
// Square-and-multiply pipeline for growth and annuity factor, one bit per six stages.
`default_nettype none
module apv_growth (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire apv_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output apv_pkg::work_t      out_data
);
  import apv_pkg::*;

  localparam int SPB  = 6;
  localparam int NBIT = SPB * PERIOD_BITS;
  localparam int NST  = NBIT + 3;

  work_t            stg_r [NST];
  logic [NST-1:0]   vld_r;
  work_t            src   [NST];
  work_t            stg_nxt [NST];
  logic [NST-1:0]   vsrc;
  logic [NST:0]     rdy;

  assign rdy[NST] = out_ready;
  assign in_ready = rdy[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = stg_r[NST-1];

  always_comb begin
    src[0]      = '0;
    src[0].item = in_data;
    src[0].g    = ONE_Q32;
    vsrc[0]     = in_valid;
  end

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_stage
      if (k > 0) begin : g_link
        assign src[k]  = stg_r[k-1];
        assign vsrc[k] = vld_r[k-1];
      end
      assign rdy[k] = !vld_r[k] || rdy[k+1];

      if (k < NBIT) begin : g_bit
        localparam int BI = PERIOD_BITS - 1 - k / SPB;
        localparam int PH = k % SPB;
        logic [64:0] m1, m2, m3;
        always_comb begin
          stg_nxt[k] = src[k];
          m1 = '0;
          m2 = '0;
          m3 = '0;
          if (PH == 0) begin
            stg_nxt[k].pa = pprod(src[k].g, src[k].s);
            stg_nxt[k].pb = pprod(src[k].g, src[k].g);
          end else if (PH == 1) begin
            m1 = qjoin(src[k].pa);
            m2 = qjoin(src[k].pb);
            stg_nxt[k].p   = m1[63:0];
            stg_nxt[k].g   = m2[63:0];
            stg_nxt[k].big = src[k].big | m1[64] | m2[64];
          end else if (PH == 2) begin
            m1 = qadd(src[k].s, src[k].p);
            stg_nxt[k].s   = m1[63:0];
            stg_nxt[k].big = src[k].big | m1[64];
          end else if (PH == 3) begin
            stg_nxt[k].pa = pprod(src[k].s, {32'b0, src[k].item.rate});
            stg_nxt[k].pb = pprod(src[k].g, {32'b0, src[k].item.rate});
          end else if (PH == 4) begin
            m1 = qjoin(src[k].pa);
            m2 = qjoin(src[k].pb);
            stg_nxt[k].p = m1[63:0];
            stg_nxt[k].h = m2[63:0];
          end else if (src[k].item.periods[BI]) begin
            m1 = qadd(src[k].s, src[k].p);
            m2 = qadd(m1[63:0], ONE_Q32);
            m3 = qadd(src[k].g, src[k].h);
            stg_nxt[k].s   = m2[63:0];
            stg_nxt[k].g   = m3[63:0];
            stg_nxt[k].big = src[k].big | m1[64] | m2[64] | m3[64];
          end
        end
      end else if (k == NBIT) begin : g_sr
        always_comb begin
          stg_nxt[k] = src[k];
          stg_nxt[k].pa = pprod(src[k].s, {32'b0, src[k].item.rate});
        end
      end else if (k == NBIT + 1) begin : g_srj
        logic [64:0] m1;
        always_comb begin
          stg_nxt[k] = src[k];
          m1 = qjoin(src[k].pa);
          stg_nxt[k].p = m1[63:0];
          stg_nxt[k].big = src[k].big | (src[k].item.at_start & m1[64]);
        end
      end else begin : g_fac
        logic [64:0] a1;
        always_comb begin
          stg_nxt[k] = src[k];
          a1 = qadd(src[k].s, src[k].p);
          stg_nxt[k].p   = src[k].item.at_start ? a1[63:0] : src[k].s;
          stg_nxt[k].big = src[k].big | (src[k].item.at_start & a1[64]);
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_r[k] <= vsrc[k];
        end
        if (rdy[k] && vsrc[k]) begin
          stg_r[k] <= stg_nxt[k];
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

FILE: rtl/apv_quot.sv
// Amount products, rounding and pipelined restoring division of the result.
`default_nettype none
module apv_quot (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire apv_pkg::work_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output apv_pkg::quot_t      out_data
);
  import apv_pkg::*;

  localparam int PRE = 5;
  localparam int NST = PRE + QUOT_BITS;

  quot_t          stg_r [NST];
  logic [NST-1:0] vld_r;
  quot_t          src   [NST];
  quot_t          stg_nxt [NST];
  logic [NST-1:0] vsrc;
  logic [NST:0]   rdy;

  assign rdy[NST]  = out_ready;
  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = stg_r[NST-1];

  always_comb begin
    src[0]      = '0;
    src[0].func = in_data.item.func;
    src[0].pmt  = in_data.item.payment_in;
    src[0].pv   = in_data.item.present_in;
    src[0].fv   = in_data.item.future_in;
    src[0].g    = in_data.g;
    src[0].a    = in_data.p;
    src[0].big  = in_data.big;
    vsrc[0]     = in_valid;
  end

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_stage
      if (k > 0) begin : g_link
        assign src[k]  = stg_r[k-1];
        assign vsrc[k] = vld_r[k-1];
      end
      assign rdy[k] = !vld_r[k] || rdy[k+1];

      if (k == 0) begin : g_mul
        logic [AMOUNT_W-1:0] x1, x2;
        logic [63:0]         u1, u2;
        always_comb begin
          stg_nxt[k] = src[k];
          x1 = (src[k].func == FN_PMT) ? src[k].pv : src[k].pmt;
          u1 = (src[k].func == FN_PMT) ? src[k].g : src[k].a;
          x2 = (src[k].func == FN_FV) ? src[k].pv : src[k].fv;
          u2 = (src[k].func == FN_FV) ? src[k].g : ONE_Q32;
          stg_nxt[k].pa = spprod(x1, u1);
          stg_nxt[k].pb = spprod(x2, u2);
        end
      end else if (k == 1) begin : g_join
        always_comb begin
          stg_nxt[k] = src[k];
          stg_nxt[k].t1 = sjoin(src[k].pa);
          stg_nxt[k].t2 = sjoin(src[k].pb);
        end
      end else if (k == 2) begin : g_sum
        always_comb begin
          stg_nxt[k] = src[k];
          stg_nxt[k].num = -($signed({src[k].t1[113], src[k].t1})
                           + $signed({src[k].t2[113], src[k].t2}));
        end
      end else if (k == 3) begin : g_mag
        logic [115:0]        mag;
        logic signed [115:0] rr;
        always_comb begin
          stg_nxt[k] = src[k];
          stg_nxt[k].neg = src[k].num[114];
          mag = src[k].num[114] ? (116'd0 - {src[k].num[114], src[k].num})
                                : {src[k].num[114], src[k].num};
          stg_nxt[k].d  = (src[k].func == FN_PMT) ? src[k].a : src[k].g;
          stg_nxt[k].m  = mag + {53'b0, stg_nxt[k].d[63:1]};
          stg_nxt[k].dz = (src[k].func == FN_PMT) && (src[k].a == 64'b0);
          rr = $signed({src[k].num[114], src[k].num}) + 116'sh8000_0000;
          stg_nxt[k].sat2 = !((&rr[115:79]) || !(|rr[115:79]));
          if (stg_nxt[k].sat2) begin
            stg_nxt[k].v2 = rr[115] ? {1'b1, {(AMOUNT_W-1){1'b0}}}
                                    : {1'b0, {(AMOUNT_W-1){1'b1}}};
          end else begin
            stg_nxt[k].v2 = rr[79:32];
          end
        end
      end else if (k == 4) begin : g_ovf
        always_comb begin
          stg_nxt[k] = src[k];
          stg_nxt[k].ovf = src[k].m >= {4'b0, src[k].d, 48'b0};
          stg_nxt[k].rem = src[k].m[111:48];
          stg_nxt[k].low = src[k].m[QUOT_BITS-1:0];
          stg_nxt[k].q   = '0;
        end
      end else begin : g_div
        logic [64:0] t;
        logic        ge;
        always_comb begin
          stg_nxt[k] = src[k];
          t  = {src[k].rem, src[k].low[QUOT_BITS-1]};
          ge = t >= {1'b0, src[k].d};
          stg_nxt[k].rem = ge ? 64'(t - {1'b0, src[k].d}) : t[63:0];
          stg_nxt[k].low = {src[k].low[QUOT_BITS-2:0], 1'b0};
          stg_nxt[k].q   = {src[k].q[QUOT_BITS-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_r[k] <= vsrc[k];
        end
        if (rdy[k] && vsrc[k]) begin
          stg_r[k] <= stg_nxt[k];
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

FILE: rtl/annuity_payment_value_unit.sv
// Annuity payment / present value / future value unit, top level.
//
// Input channel in_valid/in_ready/in_data carries one transaction per item:
// function select, rate (Q0.32), period count, three Q32.16 amounts and the
// payment timing flag. Output channel out_valid/out_ready/out_data returns
// exactly one transaction per item, in order: the Q32.16 amount and status.
// From acceptance to out_valid an item passes 72 stages of growth
// square-and-multiply (six per period bit: partial products and their sum for
// each of the two product steps, the sum update and the conditional step),
// 3 for the annuity factor, 5 for the amount products and rounding, 48 for
// the quotient (one bit per stage) and the output register. The pipeline takes
// one item per cycle while out_ready is high; every stage holds a valid bit and
// a stage loads whenever it is empty or its successor moves, so bubbles close up.
// When out_ready is low, the output register holds its transaction and the
// stages behind it keep filling until full; only then in_ready drops.
// Synchronous reset clears all valid bits; data registers are not reset.
`default_nettype none
module annuity_payment_value_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire apv_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output apv_pkg::out_t     out_data
);
  import apv_pkg::*;

  logic  gr_valid, gr_ready;
  work_t gr_data;
  logic  qt_valid, qt_ready;
  quot_t qt_data;
  logic  out_valid_r;
  out_t  out_data_r, out_data_nxt;
  logic  sat;

  apv_growth u_growth (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (gr_valid),
    .out_ready (gr_ready),
    .out_data  (gr_data)
  );

  apv_quot u_quot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gr_valid),
    .in_ready  (gr_ready),
    .in_data   (gr_data),
    .out_valid (qt_valid),
    .out_ready (qt_ready),
    .out_data  (qt_data)
  );

  assign qt_ready = !out_valid_r || out_ready;

  always_comb begin
    out_data_nxt = '0;
    sat = 1'b0;
    case (qt_data.func)
      FN_NONE: begin
        out_data_nxt.status = STAT_OK;
      end
      FN_FV: begin
        out_data_nxt.result_value = qt_data.v2;
        out_data_nxt.status = (qt_data.sat2 || qt_data.big) ? STAT_SAT : STAT_OK;
      end
      default: begin
        if (qt_data.dz) begin
          out_data_nxt.status = STAT_DIV0;
        end else begin
          if (!qt_data.neg) begin
            sat = qt_data.ovf || qt_data.q[QUOT_BITS-1];
            out_data_nxt.result_value = sat ? {1'b0, {(AMOUNT_W-1){1'b1}}} : qt_data.q;
          end else begin
            sat = qt_data.ovf || (qt_data.q[QUOT_BITS-1] && (|qt_data.q[QUOT_BITS-2:0]));
            out_data_nxt.result_value = sat ? {1'b1, {(AMOUNT_W-1){1'b0}}}
                                            : (~qt_data.q) + 48'd1;
          end
          out_data_nxt.status = (sat || qt_data.big) ? STAT_SAT : STAT_OK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (qt_ready) begin
      out_valid_r <= qt_valid;
    end
    if (qt_ready && qt_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div0_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STAT_DIV0) |-> (out_data.result_value == '0))
    else $error("division-by-zero result is not zero");

  a_full_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while pipeline can advance");

  a_reset_empty : assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

endmodule
`default_nettype wire
